/* rtl/core/mbba_pkg.sv */
// ----------------------------------------------------------------------------
// mbba_pkg
// Shared types and constants for the multi-block bump allocator.
// ----------------------------------------------------------------------------
package mbba_pkg;

	localparam int MAX_BLOCKS_DEF = 8;
	localparam int SIZE_BITS_DEF  = 32;

	localparam int          ALIGN_W         = 4;
	localparam logic [3:0]  ALIGN_LOG2_MAX  = 4'd12;
	localparam logic [3:0]  ALIGN_LOG2_RST  = 4'd4;
	localparam int          CFG_DATA_W      = 32;
	localparam int          CFG_IDX_W       = 1;
	localparam logic [31:0] DEFAULT_BLK_RST = 32'd65536;

	localparam int REQ_BYTES_W = 32;
	localparam int SLOT_W      = 3;
	localparam int OFFSET_W    = 32;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ALIGN_LOG2  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_BLK = 1'd1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ZERO  = 2'd1,
		ST_FULL  = 2'd2,
		ST_RESET = 2'd3
	} status_t;

	// broadcast controls from the sequencer to every cell
	typedef struct packed {
		logic alloc_go;
		logic clear_all;
		logic exact;
	} cell_ctl_t;

	// what a cell reports back for the current request
	typedef struct packed {
		logic take;
		logic fresh;
	} cell_hit_t;

endpackage

/* rtl/core/mbba_req_if.sv */
// ----------------------------------------------------------------------------
// mbba_req_if
// Request channel: valid/ready handshake with the allocate or reset request.
// ----------------------------------------------------------------------------
interface mbba_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] req_bytes;
	logic        exact_block;

	modport source (output valid, output kind, output req_bytes, output exact_block,
		input ready);
	modport sink (input valid, input kind, input req_bytes, input exact_block,
		output ready);
endinterface

/* rtl/core/mbba_rsp_if.sv */
// ----------------------------------------------------------------------------
// mbba_rsp_if
// Response channel: valid/ready handshake with the allocation result.
// ----------------------------------------------------------------------------
interface mbba_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [2:0]  slot;
	logic [31:0] start_offset;
	logic        opened_new;

	modport source (output valid, output status, output slot, output start_offset,
		output opened_new, input ready);
	modport sink (input valid, input status, input slot, input start_offset,
		input opened_new, output ready);
endinterface

/* rtl/core/mbba_cell.sv */
// ----------------------------------------------------------------------------
// mbba_cell
// One block slot: capacity, bump offset and open flag, with its fit check
// and a claim bit that ripples to the next slot.
// ----------------------------------------------------------------------------
module mbba_cell #(
	parameter int SIZE_BITS = mbba_pkg::SIZE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mbba_pkg::cell_ctl_t   ctl,
	input  logic [3:0]            align_lg,
	input  logic [SIZE_BITS-1:0]  size,
	input  logic [SIZE_BITS-1:0]  new_cap,
	input  logic                  claim_in,
	output logic                  claim_out,
	output mbba_pkg::cell_hit_t   hit,
	output logic [SIZE_BITS:0]    offset
);

	localparam int SW = SIZE_BITS + 2;

	logic                 open_q;
	logic [SIZE_BITS:0]   used_q;
	logic [SIZE_BITS-1:0] cap_q;

	logic [SW-1:0] mask;
	logic [SW-1:0] aligned;
	logic [SW-1:0] bump;
	logic          fits;
	logic          want;

	always_comb begin
		mask    = ~({SW{1'b1}} << align_lg);
		aligned = ({1'b0, used_q} + mask) & ~mask;
		bump    = aligned + SW'(size);
		fits    = (bump <= {2'b00, cap_q}) && (!ctl.exact || cap_q == size);
		// a closed slot always wants the request: it is the first free one
		want    = open_q ? fits : 1'b1;
	end

	assign claim_out = claim_in | want;
	assign hit.take  = ctl.alloc_go & ~claim_in & want;
	assign hit.fresh = ~open_q;
	assign offset    = open_q ? aligned[SIZE_BITS:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			used_q <= '0;
		end else if (ctl.clear_all) begin
			used_q <= '0;
		end else if (hit.take) begin
			open_q <= 1'b1;
			used_q <= open_q ? bump[SIZE_BITS:0] : {1'b0, size};
		end
	end

	always_ff @(posedge clk) begin
		if (hit.take && !open_q) begin
			cap_q <= new_cap;
		end
	end

endmodule

/* rtl/core/multi_block_bump_allocator.sv */
// An accepted request is captured into registers, then evaluated by the cell
// row; its result is registered once the result register is free or being read,
// and no new request is accepted before that. Fit check and first-fit claim
// ripple combinationally through all slots in the evaluation; a stalled result
// holds it. Reset closes every slot, zeroes offsets and loads register defaults;
// no clearing pass, requests are taken right after reset.
// ----------------------------------------------------------------------------
// multi_block_bump_allocator
// First-fit bump allocator over a row of block slots.
// ----------------------------------------------------------------------------
module multi_block_bump_allocator #(
	parameter int MAX_BLOCKS = mbba_pkg::MAX_BLOCKS_DEF,
	parameter int SIZE_BITS  = mbba_pkg::SIZE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mbba_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mbba_pkg::CFG_DATA_W-1:0]  cfg_data,
	mbba_req_if.sink                         req,
	mbba_rsp_if.source                       rsp
);

	localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int SLOT_X = (IDX_W > mbba_pkg::SLOT_W) ? IDX_W : mbba_pkg::SLOT_W;
	localparam int WIDE   = (SIZE_BITS > 32) ? SIZE_BITS : 32;
	localparam int OFF_X  = (SIZE_BITS + 1 > mbba_pkg::OFFSET_W) ?
		SIZE_BITS + 1 : mbba_pkg::OFFSET_W;

	// configuration
	logic [3:0]  align_q;
	logic [31:0] def_blk_q;
	logic [3:0]  align_lg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_q   <= mbba_pkg::ALIGN_LOG2_RST;
			def_blk_q <= mbba_pkg::DEFAULT_BLK_RST;
		end else if (cfg_we) begin
			if (cfg_index == mbba_pkg::REG_ALIGN_LOG2) begin
				align_q <= cfg_data[3:0];
			end else if (cfg_index == mbba_pkg::REG_DEFAULT_BLK) begin
				def_blk_q <= cfg_data[31:0];
			end
		end
	end

	assign align_lg = (align_q > mbba_pkg::ALIGN_LOG2_MAX) ? mbba_pkg::ALIGN_LOG2_MAX : align_q;

	// request capture
	logic                 busy_q;
	logic                 kind_s1;
	logic                 exact_s1;
	logic [SIZE_BITS-1:0] size_s1;
	logic [SIZE_BITS-1:0] new_cap_s1;
	logic                 commit;
	logic                 req_fire;

	logic [WIDE-1:0]      req_wide;
	logic [WIDE-1:0]      def_wide;
	logic [SIZE_BITS-1:0] req_size;
	logic [SIZE_BITS-1:0] req_cap;

	assign req_wide = WIDE'(req.req_bytes);
	assign def_wide = WIDE'(def_blk_q);
	assign req_size = req_wide[SIZE_BITS-1:0];
	assign req_cap  = (!req.exact_block && def_wide > WIDE'(req_size)) ?
		def_wide[SIZE_BITS-1:0] : req_size;

	logic out_valid_q;

	assign req.ready = ~busy_q;
	assign req_fire  = req.valid & ~busy_q;
	assign commit    = busy_q & (~out_valid_q | rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req_fire) begin
			busy_q <= 1'b1;
		end else if (commit) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_s1    <= req.kind;
			exact_s1   <= req.exact_block;
			size_s1    <= req_size;
			new_cap_s1 <= req_cap;
		end
	end

	// cell row
	mbba_pkg::cell_ctl_t ctl;
	logic                size_zero;
	logic [MAX_BLOCKS:0] claim;
	mbba_pkg::cell_hit_t hits [MAX_BLOCKS];
	logic [SIZE_BITS:0]  offs [MAX_BLOCKS];

	assign size_zero     = (size_s1 == '0);
	assign ctl.alloc_go  = commit & ~kind_s1 & ~size_zero;
	assign ctl.clear_all = commit & kind_s1;
	assign ctl.exact     = exact_s1;
	assign claim[0]      = 1'b0;

	for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
		mbba_cell #(
			.SIZE_BITS (SIZE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.align_lg  (align_lg),
			.size      (size_s1),
			.new_cap   (new_cap_s1),
			.claim_in  (claim[g]),
			.claim_out (claim[g+1]),
			.hit       (hits[g]),
			.offset    (offs[g])
		);
	end

	// gather the single winning cell
	logic [IDX_W-1:0]     win_idx;
	logic [SIZE_BITS:0]   win_off;
	logic                 win_fresh;
	logic [SLOT_X-1:0]    slot_x;
	logic [OFF_X-1:0]     off_x;

	always_comb begin
		win_idx   = '0;
		win_off   = '0;
		win_fresh = 1'b0;
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			if (hits[i].take) begin
				win_idx   = win_idx | IDX_W'(i);
				win_off   = win_off | offs[i];
				win_fresh = win_fresh | hits[i].fresh;
			end
		end
	end

	assign slot_x = SLOT_X'(win_idx);
	assign off_x  = OFF_X'(win_off);

	// result register
	mbba_pkg::status_t    status_q;
	logic [2:0]           slot_q;
	logic [31:0]          offset_q;
	logic                 fresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			slot_q   <= '0;
			offset_q <= '0;
			fresh_q  <= 1'b0;
			if (kind_s1) begin
				status_q <= mbba_pkg::ST_RESET;
			end else if (size_zero) begin
				status_q <= mbba_pkg::ST_ZERO;
			end else if (!claim[MAX_BLOCKS]) begin
				status_q <= mbba_pkg::ST_FULL;
			end else begin
				status_q <= mbba_pkg::ST_OK;
				slot_q   <= slot_x[mbba_pkg::SLOT_W-1:0];
				offset_q <= off_x[mbba_pkg::OFFSET_W-1:0];
				fresh_q  <= win_fresh;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = status_q;
	assign rsp.slot         = slot_q;
	assign rsp.start_offset = offset_q;
	assign rsp.opened_new   = fresh_q;

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and clear requests into the bump allocator with random
// request gaps and response stalls, predicts every grant from a local model
// of the block table, and compares each response field by field.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mbba_pkg::*;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;
	localparam int   SLOTS          = MAX_BLOCKS_DEF;
	localparam int   DRAIN_CYCLES   = 4;
	localparam int   PHASES         = 8;
	localparam int   PHASE_REQUESTS = 140;

	typedef struct packed {
		status_t     status;
		logic [2:0]  slot;
		logic [31:0] offset;
		logic        opened;
	} grant_t;

	typedef enum logic {ROW_REQ, ROW_CFG} row_op_t;

	typedef struct packed {
		row_op_t               op;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic                  kind;
		logic [31:0]           bytes;
		logic                  exact;
		logic                  typed;
		grant_t                want;
	} stim_row_t;

	localparam grant_t NO_WANT = '{ST_OK, 3'd0, 32'd0, 1'b0};

	// rows with typed=1 carry the expected grant written out directly
	localparam stim_row_t DIR_TBL [25] = '{
		'{ROW_REQ, 1'b0, KIND_ALLOC, 32'd0, 1'b0, 1'b1, '{ST_ZERO, 3'd0, 32'd0, 1'b0}},
		'{ROW_REQ, 1'b0, KIND_CLEAR, 32'd0, 1'b0, 1'b1, '{ST_RESET, 3'd0, 32'd0, 1'b0}},
		'{ROW_REQ, 1'b0, KIND_ALLOC, 32'd100, 1'b0, 1'b1, '{ST_OK, 3'd0, 32'd0, 1'b1}},
		'{ROW_REQ, 1'b0, KIND_ALLOC, 32'd1, 1'b0, 1'b0, NO_WANT},
		'{ROW_CFG, REG_DEFAULT_BLK, KIND_ALLOC, 32'd1, 1'b0, 1'b0, NO_WANT},
		'{ROW_REQ, 1'b0, KIND_ALLOC, 32'd65500, 1'b0, 1'b0, NO_WANT},
		'{ROW_REQ, 1'b0, KIND_ALLOC, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_WANT},
		'{ROW_REQ, 1'b0, KIND_ALLOC, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_WANT},
		'{ROW_CFG, REG_DEFAULT_BLK, KIND_ALLOC, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_WANT},
		'{ROW_REQ, 1'b0, KIND_ALLOC, 32'd4096, 1'b1, 1'b0, NO_WANT},
		'{ROW_REQ, 1'b0, KIND_ALLOC, 32'd4096, 1'b1, 1'b0, NO_WANT},
		'{ROW_REQ, 1'b0, KIND_ALLOC, 32'd1, 1'b1, 1'b0, NO_WANT},
		'{ROW_REQ, 1'b0, KIND_ALLOC, 32'd7, 1'b0, 1'b0, NO_WANT},
		'{ROW_REQ, 1'b0, KIND_ALLOC, 32'd70000, 1'b0, 1'b0, NO_WANT},
		'{ROW_REQ, 1'b0, KIND_ALLOC, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_WANT},
		'{ROW_REQ, 1'b0, KIND_CLEAR, 32'hFFFF_FFFF, 1'b1, 1'b1,
			'{ST_RESET, 3'd0, 32'd0, 1'b0}},
		'{ROW_REQ, 1'b0, KIND_ALLOC, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_WANT},
		'{ROW_REQ, 1'b0, KIND_ALLOC, 32'd1, 1'b1, 1'b0, NO_WANT},
		'{ROW_REQ, 1'b0, KIND_ALLOC, 32'd1, 1'b1, 1'b0, NO_WANT},
		'{ROW_REQ, 1'b0, KIND_ALLOC, 32'd0, 1'b1, 1'b1, '{ST_ZERO, 3'd0, 32'd0, 1'b0}},
		'{ROW_CFG, REG_ALIGN_LOG2, KIND_ALLOC, 32'd0, 1'b0, 1'b0, NO_WANT},
		'{ROW_REQ, 1'b0, KIND_ALLOC, 32'd3, 1'b0, 1'b0, NO_WANT},
		'{ROW_REQ, 1'b0, KIND_ALLOC, 32'd5, 1'b0, 1'b0, NO_WANT},
		'{ROW_CFG, REG_ALIGN_LOG2, KIND_ALLOC, 32'd15, 1'b0, 1'b0, NO_WANT},
		'{ROW_REQ, 1'b0, KIND_ALLOC, 32'd1, 1'b0, 1'b0, NO_WANT}
	};

	localparam logic [3:0]  ALIGN_PLAN [PHASES] = '{
		4'd0, 4'd12, 4'd15, 4'd4, 4'd1, 4'd7, 4'd13, 4'd2
	};
	localparam logic [31:0] DEFAULT_PLAN [PHASES] = '{
		32'd1, 32'hFFFF_FFFF, 32'd65536, 32'd4096, 32'd300, 32'h8000_0000, 32'd17, 32'd65536
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mbba_req_if req_ch ();
	mbba_rsp_if rsp_ch ();

	multi_block_bump_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// local copy of the block table and registers
	logic [31:0] cap_tbl [SLOTS];
	logic [32:0] used_tbl [SLOTS];
	int unsigned open_cnt;
	logic [3:0]  align_cfg;
	logic [31:0] default_cfg;

	grant_t expected_grants [$];
	bit     failed;
	bit     calm;

	function automatic grant_t bump_allocate(input logic kind, input logic [31:0] bytes,
		input logic exact);
		grant_t      g;
		logic [3:0]  lg;
		logic [33:0] amask;
		logic [33:0] aligned;
		logic [31:0] cap;
		g = '{ST_OK, 3'd0, 32'd0, 1'b0};
		if (kind == KIND_CLEAR) begin
			for (int i = 0; i < SLOTS; i++) used_tbl[i] = '0;
			g.status = ST_RESET;
			return g;
		end
		if (bytes == 32'd0) begin
			g.status = ST_ZERO;
			return g;
		end
		lg = (align_cfg > ALIGN_LOG2_MAX) ? ALIGN_LOG2_MAX : align_cfg;
		amask = (34'd1 << lg) - 34'd1;
		for (int i = 0; i < open_cnt; i++) begin
			aligned = ({1'b0, used_tbl[i]} + amask) & ~amask;
			if ((aligned + bytes <= cap_tbl[i]) && (!exact || cap_tbl[i] == bytes)) begin
				used_tbl[i] = aligned[32:0] + bytes;
				g.slot = 3'(i);
				g.offset = aligned[31:0];
				return g;
			end
		end
		if (open_cnt >= SLOTS) begin
			g.status = ST_FULL;
			return g;
		end
		cap = (!exact && default_cfg > bytes) ? default_cfg : bytes;
		cap_tbl[open_cnt] = cap;
		used_tbl[open_cnt] = {1'b0, bytes};
		g.slot = 3'(open_cnt);
		g.opened = 1'b1;
		open_cnt++;
		return g;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic push_request(input logic kind, input logic [31:0] bytes,
		input logic exact, input logic typed, input grant_t want);
		int     gap;
		grant_t g;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.kind = kind;
		req_ch.req_bytes = bytes;
		req_ch.exact_block = exact;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		g = bump_allocate(kind, bytes, exact);
		expected_grants.push_back(typed ? want : g);
		@(negedge clk);
	endtask

	// drop the request line and wait out every outstanding grant
	task automatic settle();
		req_ch.valid = 1'b0;
		while (expected_grants.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_ALIGN_LOG2) begin
			align_cfg = value[3:0];
		end else begin
			default_cfg = value;
		end
	endtask

	task automatic roll_request(output logic kind, output logic [31:0] bytes,
		output logic exact);
		int unsigned pick;
		logic [31:0] cap;
		pick = $urandom_range(0, 99);
		kind = KIND_ALLOC;
		exact = ($urandom_range(0, 4) == 0);
		cap = (open_cnt > 0) ? cap_tbl[$urandom_range(0, open_cnt - 1)] : 32'd4096;
		if (pick < 6) begin
			kind = KIND_CLEAR;
			bytes = $urandom;
		end else if (pick < 9) begin
			bytes = 32'd0;
		end else if (pick < 34) begin
			bytes = cap;
			exact = 1'b1;
		end else if (pick < 74) begin
			bytes = $urandom_range(1, 256);
		end else if (pick < 88) begin
			bytes = $urandom_range(1, 70000);
		end else if (pick < 94) begin
			bytes = $urandom;
		end else begin
			// at or just under a known capacity
			bytes = (cap > 32'd64) ? cap - $urandom_range(0, 64) : cap;
		end
	endtask

	always @(posedge clk) begin
		grant_t e;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_grants.size() == 0) begin
				$error("response with no request outstanding");
				failed = 1'b1;
			end else begin
				e = expected_grants.pop_front();
				if (rsp_ch.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, rsp_ch.status);
					failed = 1'b1;
				end
				if (rsp_ch.slot !== e.slot) begin
					$error("slot: expected %0d, got %0d", e.slot, rsp_ch.slot);
					failed = 1'b1;
				end
				if (rsp_ch.start_offset !== e.offset) begin
					$error("start_offset: expected %0d, got %0d", e.offset,
						rsp_ch.start_offset);
					failed = 1'b1;
				end
				if (rsp_ch.opened_new !== e.opened) begin
					$error("opened_new: expected %0d, got %0d", e.opened, rsp_ch.opened_new);
					failed = 1'b1;
				end
			end
		end
	end

	// response side: stall a random number of cycles before each grant
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		#1_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic        kind;
		logic [31:0] bytes;
		logic        exact;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_ALLOC;
		req_ch.req_bytes = '0;
		req_ch.exact_block = 1'b0;
		failed = 1'b0;
		calm = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			cap_tbl[i] = '0;
			used_tbl[i] = '0;
		end
		open_cnt = 0;
		align_cfg = ALIGN_LOG2_RST;
		default_cfg = DEFAULT_BLK_RST;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (DIR_TBL[i]) begin
			if (DIR_TBL[i].op == ROW_CFG) begin
				settle();
				write_reg(DIR_TBL[i].reg_idx, DIR_TBL[i].bytes);
			end else begin
				push_request(DIR_TBL[i].kind, DIR_TBL[i].bytes, DIR_TBL[i].exact,
					DIR_TBL[i].typed, DIR_TBL[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			calm = (ph % 3 == 2);
			write_reg(REG_ALIGN_LOG2, {28'd0, ALIGN_PLAN[ph]});
			write_reg(REG_DEFAULT_BLK, DEFAULT_PLAN[ph]);
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				roll_request(kind, bytes, exact);
				push_request(kind, bytes, exact, 1'b0, NO_WANT);
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (!failed) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
